>>> sv/itwt_pkg.sv
// shared types and constants for the integer to word token converter
package itwt_pkg;

    localparam int VALUE_W   = 31;
    localparam int WORD_W    = 5;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int SHIFT_W   = 5;
    localparam int GROUP_W   = 2;
    localparam int STEP_W    = 3;

    localparam logic [WORD_W-1:0] WORD_ZERO    = 5'd0;
    localparam logic [WORD_W-1:0] WORD_TEEN    = 5'd10;
    localparam logic [WORD_W-1:0] TENS_BASE    = 5'd18;
    localparam logic [WORD_W-1:0] WORD_HUNDRED = 5'd28;
    localparam logic [WORD_W-1:0] WORD_BILLION = 5'd31;

    localparam logic [SHIFT_W-1:0] LAST_SHIFT = SHIFT_W'(VALUE_W - 1);
    localparam logic [GROUP_W-1:0] LAST_GROUP = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_WALK
    } t_state;

    typedef enum logic [STEP_W-1:0] {
        STEP_HUND_DIGIT,
        STEP_HUNDRED,
        STEP_TENS,
        STEP_UNITS,
        STEP_SCALE
    } t_step;

endpackage

>>> sv/integer_to_word_tokens.sv
// integer to english word tokens: bit-serial binary to bcd, then a word sequencer
//
// Pulse start while busy is low to hand over i_value (31 bits, unsigned).
// The block converts the value to ten decimal digits by shift-and-add-3, one
// input bit per cycle, then walks the billions, millions, thousands and units
// groups, five slots per group (hundreds digit, "hundred", tens or teen,
// units, scale word). Each word comes out on o_word for one cycle with o_valid
// high, o_last marking the final word of the number; zero gives the single
// word Zero. A word found in a slot is held until the next word is found or
// the walk ends, and then goes out through the output register. Busy drops in
// the cycle the last word is shown, so the next start can be taken in that
// same cycle. The receiver cannot stall and must take every word in the cycle
// it is shown.
module integer_to_word_tokens
    import itwt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    output logic [WORD_W-1:0]  o_word,
    output logic               o_last
);

    t_state               r_state, n_state;
    logic [VALUE_W-1:0]   r_val, n_val;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [SHIFT_W-1:0]   r_cnt, n_cnt;
    logic [GROUP_W-1:0]   r_group, n_group;
    t_step                r_step, n_step;
    logic                 r_pend_vld, n_pend_vld;
    logic [WORD_W-1:0]    r_pend_word, n_pend_word;
    logic                 r_valid, n_valid;
    logic [WORD_W-1:0]    r_word, n_word;
    logic                 r_last, n_last;

    logic [BCD_W-1:0]     adj;
    logic [3:0]           dig_h, dig_t, dig_u;
    logic                 hit;
    logic [WORD_W-1:0]    hit_word;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                      : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        case (r_group)
            2'd0: begin
                dig_h = 4'd0;
                dig_t = 4'd0;
                dig_u = r_bcd[39:36];
            end
            2'd1: begin
                dig_h = r_bcd[35:32];
                dig_t = r_bcd[31:28];
                dig_u = r_bcd[27:24];
            end
            2'd2: begin
                dig_h = r_bcd[23:20];
                dig_t = r_bcd[19:16];
                dig_u = r_bcd[15:12];
            end
            default: begin
                dig_h = r_bcd[11:8];
                dig_t = r_bcd[7:4];
                dig_u = r_bcd[3:0];
            end
        endcase
    end

    // word found in the current slot, if any
    always_comb begin
        hit      = 1'b0;
        hit_word = WORD_ZERO;
        case (r_step)
            STEP_HUND_DIGIT: begin
                hit      = (dig_h != 4'd0);
                hit_word = {1'b0, dig_h};
            end
            STEP_HUNDRED: begin
                hit      = (dig_h != 4'd0);
                hit_word = WORD_HUNDRED;
            end
            STEP_TENS: begin
                if (dig_t == 4'd1) begin
                    hit      = 1'b1;
                    hit_word = WORD_TEEN + {1'b0, dig_u};
                end else begin
                    hit      = (dig_t != 4'd0);
                    hit_word = TENS_BASE + {1'b0, dig_t};
                end
            end
            STEP_UNITS: begin
                hit      = (dig_t != 4'd1) && (dig_u != 4'd0);
                hit_word = {1'b0, dig_u};
            end
            STEP_SCALE: begin
                hit      = (r_group != LAST_GROUP) &&
                           ((dig_h != 4'd0) || (dig_t != 4'd0) || (dig_u != 4'd0));
                hit_word = WORD_BILLION - {3'b000, r_group};
            end
            default: begin
                hit      = 1'b0;
                hit_word = WORD_ZERO;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_group     = r_group;
        n_step      = r_step;
        n_pend_vld  = r_pend_vld;
        n_pend_word = r_pend_word;
        n_valid     = 1'b0;
        n_word      = r_word;
        n_last      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val      = i_value;
                    n_bcd      = '0;
                    n_cnt      = '0;
                    n_group    = '0;
                    n_step     = STEP_HUND_DIGIT;
                    n_pend_vld = 1'b0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {adj[BCD_W-2:0], r_val[VALUE_W-1]};
                n_val = {r_val[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_SHIFT) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_step == STEP_SCALE && r_group == LAST_GROUP) begin
                    // units group has no scale word, so only the held word (or Zero if none is held) goes out
                    n_valid = 1'b1;
                    n_last  = 1'b1;
                    n_word  = r_pend_vld ? r_pend_word : WORD_ZERO;
                    n_state = S_IDLE;
                end else begin
                    if (hit) begin
                        n_valid     = r_pend_vld;
                        n_word      = r_pend_word;
                        n_pend_vld  = 1'b1;
                        n_pend_word = hit_word;
                    end
                    if (r_step == STEP_SCALE) begin
                        n_step  = STEP_HUND_DIGIT;
                        n_group = r_group + 1'b1;
                    end else begin
                        n_step = t_step'(r_step + 1'b1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_vld <= 1'b0;
            r_valid    <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_valid    <= n_valid;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val       <= n_val;
        r_bcd       <= n_bcd;
        r_cnt       <= n_cnt;
        r_group     <= n_group;
        r_step      <= n_step;
        r_pend_word <= n_pend_word;
        r_word      <= n_word;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_last  = r_last;

endmodule

>>> tb/integer_to_word_tokens_checker.sv
// word run checker: predicts the word codes of each accepted value and compares them
`timescale 1ns / 1ps

module itwt_word_checker
    import itwt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               o_valid,
    input  logic [WORD_W-1:0]  o_word,
    input  logic               o_last,
    output int                 fail_count,
    output int                 words_pending
);

    localparam logic [WORD_W-1:0] WORD_THOUSAND = 5'd29;
    localparam logic [WORD_W-1:0] WORD_MILLION  = 5'd30;
    localparam int REPORT_LIMIT = 10;

    logic [WORD_W-1:0] spoken_word_q[$];
    bit                final_flag_q[$];

    initial begin
        fail_count    = 0;
        words_pending = 0;
    end

    // one group of up to three digits, without its scale word
    function automatic void spell_group(input int unsigned grp);
        int unsigned hund;
        int unsigned rest;
        hund = grp / 100;
        rest = grp % 100;
        if (hund != 0) begin
            spoken_word_q.push_back(5'(hund));
            spoken_word_q.push_back(WORD_HUNDRED);
        end
        if (rest >= 10 && rest <= 19) begin
            spoken_word_q.push_back(5'(rest));
        end else begin
            if (rest / 10 != 0)
                spoken_word_q.push_back(TENS_BASE + 5'(rest / 10));
            if (rest % 10 != 0)
                spoken_word_q.push_back(5'(rest % 10));
        end
    endfunction

    function automatic void spell_value(input logic [VALUE_W-1:0] val);
        int unsigned num;
        int unsigned billions;
        int unsigned millions;
        int unsigned thousands;
        int unsigned units;
        int          first;
        int          count;
        num       = val;
        billions  = num / 1000000000;
        millions  = (num / 1000000) % 1000;
        thousands = (num / 1000) % 1000;
        units     = num % 1000;
        first     = spoken_word_q.size();
        if (num == 0) begin
            spoken_word_q.push_back(WORD_ZERO);
        end else begin
            // a zero group says nothing, not even its scale word
            if (billions != 0) begin
                spell_group(billions);
                spoken_word_q.push_back(WORD_BILLION);
            end
            if (millions != 0) begin
                spell_group(millions);
                spoken_word_q.push_back(WORD_MILLION);
            end
            if (thousands != 0) begin
                spell_group(thousands);
                spoken_word_q.push_back(WORD_THOUSAND);
            end
            if (units != 0)
                spell_group(units);
        end
        count = spoken_word_q.size() - first;
        for (int k = 0; k < count; k++)
            final_flag_q.push_back(k == count - 1);
    endfunction

    always @(posedge i_clk) begin : watch
        logic [WORD_W-1:0] exp_word;
        bit                exp_last;
        if (i_rst_n) begin
            if (o_valid) begin
                if (spoken_word_q.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%t: unexpected word %0d last %0b", $realtime, o_word, o_last);
                    fail_count = fail_count + 1;
                end else begin
                    exp_word = spoken_word_q.pop_front();
                    exp_last = final_flag_q.pop_front();
                    if (o_word !== exp_word || o_last !== exp_last) begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%t: word mismatch: expected %0d last %0b, got %0d last %0b",
                                     $realtime, exp_word, exp_last, o_word, o_last);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                spell_value(i_value);
        end
        words_pending = spoken_word_q.size();
    end

endmodule

>>> tb/integer_to_word_tokens_test.sv
// testbench top: clock, reset and value stimulus for the word token converter
`timescale 1ns / 1ps

module integer_to_word_tokens_test;
    import itwt_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 82;
    localparam int MAX_GAP = 60;
    localparam int TAIL_CYCLES = 60;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [VALUE_W-1:0] i_value;
    logic               o_valid;
    logic [WORD_W-1:0]  o_word;
    logic               o_last;
    int                 fail_count;
    int                 words_pending;
    int                 stall_cycles = 0;

    int unsigned directed_values [26] = '{
        0, 1, 9, 10, 11, 13, 19, 20, 21, 99, 100, 101, 110, 115, 999, 1000, 1001,
        1000000, 1000010, 1000000000, 2000000000, 2147483647, 2100000000,
        100100100, 999999999, 1010101010
    };

    always #6 i_clk = ~i_clk;

    integer_to_word_tokens uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_value (i_value),
        .o_valid (o_valid),
        .o_word  (o_word),
        .o_last  (o_last)
    );

    itwt_word_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_word        (o_word),
        .o_last        (o_last),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // ends the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("** integer_to_word_tokens: FAILED **");
            $finish;
        end
    end

    function automatic int unsigned pick_group();
        int unsigned grp;
        case ($urandom_range(0, 5))
            0: grp = 0;
            1: grp = $urandom_range(0, 19);
            2: grp = 10 * $urandom_range(0, 9);
            3: grp = 100 * $urandom_range(1, 9);
            4: grp = 100 * $urandom_range(0, 9) + $urandom_range(10, 19);
            default: grp = $urandom_range(0, 999);
        endcase
        return grp;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        longint unsigned total;
        case ($urandom_range(0, 9))
            0, 1: total = $urandom & 32'h7fff_ffff;
            2: total = $urandom_range(0, 999);
            3: total = $urandom_range(0, 999999);
            default: begin
                total = longint'($urandom_range(0, 2)) * 64'd1000000000
                      + longint'(pick_group()) * 64'd1000000
                      + longint'(pick_group()) * 64'd1000
                      + longint'(pick_group());
                // two billion plus a large remainder does not fit in 31 bits
                if (total > 64'd2147483647)
                    total = total - 64'd1000000000;
            end
        endcase
        return total[VALUE_W-1:0];
    endfunction

    // holds start high at falling edges until the block takes the transaction
    task automatic send_value(input logic [VALUE_W-1:0] val);
        start   = 1'b1;
        i_value = val;
        while (busy)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic maybe_idle(input int unsigned idle_pct);
        if ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            i_value = VALUE_W'($urandom);
            repeat ($urandom_range(1, MAX_GAP)) @(negedge i_clk);
        end
    endtask

    task automatic drain_words();
        start = 1'b0;
        while (words_pending != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int unsigned idle_pct;
        start   = 1'b0;
        i_value = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_values[k]) begin
            send_value(directed_values[k][VALUE_W-1:0]);
            maybe_idle(27);
        end
        drain_words();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: idle_pct = 27;
                1: idle_pct = 86;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_value(pick_value());
                maybe_idle(idle_pct);
            end
            drain_words();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("** integer_to_word_tokens: PASSED **");
        else
            $display("** integer_to_word_tokens: FAILED **");
        $finish;
    end

endmodule
